/* rtl/core/sos_pkg.sv */
// -----------------------------------------------------------------------------
// sos_pkg: shared types and constants of the sweep object segmenter
// Field widths, segmenter phase, register and record codes, tangent table.
// -----------------------------------------------------------------------------
package sos_pkg;

   localparam int DIST_W   = 14;
   localparam int ANGLE_W  = 9;
   localparam int WDEG_W   = 8;
   localparam int LIN_W    = 16;
   localparam int CNT_W    = 6;
   localparam int TAN_W    = 22;
   localparam int PROD_W   = DIST_W + TAN_W;
   localparam int HALF_W   = 8;
   localparam int TAN_IDX_W = 7;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam logic [CNT_W-1:0]  CNT_MAX    = 6'd63;
   localparam logic [HALF_W-1:0] HALF_LIMIT = 8'd90;
   localparam logic [LIN_W-1:0]  LIN_MAX    = 16'hFFFF;

   localparam logic [DIST_W-1:0] PING_NEAR_RST = 14'd1280;
   localparam logic [DIST_W-1:0] IR_NEAR_RST   = 14'd720;
   localparam logic [DIST_W-1:0] IR_CLEAR_RST  = 14'd1280;

   localparam logic [1:0] REG_PING_NEAR = 2'd0;
   localparam logic [1:0] REG_IR_NEAR   = 2'd1;
   localparam logic [1:0] REG_IR_CLEAR  = 2'd2;

   localparam logic KIND_OBJECT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_OBJECT = 2'd1,
      PH_CLEAR  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [DIST_W-1:0] ping_near;
      logic [DIST_W-1:0] ir_near;
      logic [DIST_W-1:0] ir_clear;
   } thresh_type;

   // after the store read is issued
   typedef struct packed {
      logic               vld;
      logic               obj;
      logic               last;
      logic               fwd;
      logic [ANGLE_W-1:0] center;
      logic [ANGLE_W-1:0] wfull;
      logic [DIST_W-1:0]  son;
   } stage1_type;

   // after the tangent multiply
   typedef struct packed {
      logic               vld;
      logic               obj;
      logic               last;
      logic               big;
      logic [ANGLE_W-1:0] center;
      logic [WDEG_W-1:0]  width_deg;
      logic [DIST_W-1:0]  distance;
      logic [PROD_W-1:0]  prod;
   } stage2_type;

   typedef struct packed {
      logic               kind;
      logic [CNT_W-1:0]   object_index;
      logic [ANGLE_W-1:0] center_deg;
      logic [DIST_W-1:0]  distance;
      logic [WDEG_W-1:0]  width_deg;
      logic [LIN_W-1:0]   linear_width;
      logic [CNT_W-1:0]   object_count;
      logic               last;
   } rsp_type;

   // tan(n degrees) in Q6.16, n = 0..89
   localparam logic [TAN_W-1:0] TAN_Q16 [90] = '{
      0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
      11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
      23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
      37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
      54991, 56970, 59009, 61113, 63287, 65536, 67865, 70279, 72785, 75391,
      78103, 80930, 83882, 86969, 90203, 93595, 97161, 100917, 104880, 109070,
      113511, 118230, 123255, 128621, 134369, 140542, 147196, 154393, 162207, 170727,
      180059, 190330, 201699, 214359, 228551, 244583, 262851, 283867, 308323, 337153,
      371673, 413778, 466313, 533748, 623533, 749080, 937208, 1250501, 1876706, 3754555
   };

endpackage

/* rtl/core/sos_if.sv */
// -----------------------------------------------------------------------------
// sos_req_if / sos_rsp_if: sample and record channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// -----------------------------------------------------------------------------
interface sos_req_if import sos_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] ir_dist;
   logic [DIST_W-1:0] sonar_dist;
   logic              last_sample;

   modport source (output valid, ir_dist, sonar_dist, last_sample, input ready);
   modport sink   (input valid, ir_dist, sonar_dist, last_sample, output ready);
endinterface

interface sos_rsp_if import sos_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [CNT_W-1:0]   object_index;
   logic [ANGLE_W-1:0] center_deg;
   logic [DIST_W-1:0]  distance;
   logic [WDEG_W-1:0]  width_deg;
   logic [LIN_W-1:0]   linear_width;
   logic [CNT_W-1:0]   object_count;
   logic               last;

   modport source (output valid, kind, object_index, center_deg, distance, width_deg,
                   linear_width, object_count, last, input ready);
   modport sink   (input valid, kind, object_index, center_deg, distance, width_deg,
                   linear_width, object_count, last, output ready);
endinterface

/* rtl/core/sos_front.sv */
// -----------------------------------------------------------------------------
// sos_front: segmenter state, sonar store and tangent multiply
// Writes each sample to the store, reads the midpoint sample of an ending
// object, looks up the tangent of the half angle and forms distance * tan.
// -----------------------------------------------------------------------------
module sos_front import sos_pkg::*; #(
   parameter int SWEEP_STEPS  = 91,
   parameter int DEG_PER_STEP = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [DIST_W-1:0] ir_dist,
   input  logic [DIST_W-1:0] sonar_dist,
   input  logic              last_sample,
   input  thresh_type        thresh,
   output stage2_type        stage2,
   output logic [1:0]        busy
);

   localparam int STEP_W = (SWEEP_STEPS > 1) ? $clog2(SWEEP_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SWEEP_STEPS - 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] start_ff, start_in;
   phase_type         phase_ff, phase_in;

   logic [DIST_W-1:0] sonar_mem [SWEEP_STEPS];
   logic [DIST_W-1:0] rd_data_ff;

   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;

   logic              obj_start, obj_end, rearm;
   logic [STEP_W:0]   step_sum;
   logic [STEP_W-1:0] mid;
   logic [10:0]       ctr_full;
   logic [ANGLE_W-1:0] wfull;

   // object decisions
   always_comb begin
      obj_start = (sonar_dist < thresh.ping_near) && (ir_dist < thresh.ir_near);
      obj_end   = (phase_ff == PH_OBJECT) &&
                  ((sonar_dist > thresh.ping_near) || (ir_dist > thresh.ir_near));
      rearm     = ir_dist > thresh.ir_clear;
   end

   // next phase, step and start
   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      step_in  = step_ff;
      if (accept) begin
         case (phase_ff)
            PH_OBJECT: begin
               if (obj_end) phase_in = PH_CLEAR;
            end
            PH_CLEAR: begin
               if (rearm) phase_in = PH_IDLE;
            end
            default: begin
               if (obj_start) begin
                  phase_in = PH_OBJECT;
                  start_in = step_ff;
               end
            end
         endcase
         if (last_sample) begin
            phase_in = PH_IDLE;
            start_in = '0;
            step_in  = '0;
         end else if (step_ff != LAST_STEP) begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   // geometry of an ending object
   always_comb begin
      step_sum = {1'b0, start_ff} + {1'b0, step_ff};
      mid      = step_sum[STEP_W:1];
      ctr_full = 11'(DEG_PER_STEP) * 11'(step_sum);
      wfull    = 9'(DEG_PER_STEP) * 9'(step_ff - start_ff);
   end

   always_comb begin
      s1_in.vld    = accept;
      s1_in.obj    = obj_end;
      s1_in.last   = last_sample;
      s1_in.fwd    = (mid == step_ff);
      s1_in.center = ctr_full[ANGLE_W:1];
      s1_in.wfull  = wfull;
      s1_in.son    = sonar_dist;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
         start_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         start_ff <= start_in;
      end
   end

   // sonar store: write this step, read the midpoint
   always_ff @(posedge clock) begin
      if (accept) begin
         sonar_mem[step_ff] <= sonar_dist;
         rd_data_ff         <= sonar_mem[mid];
      end
   end

   logic [DIST_W-1:0] mid_son;
   logic [HALF_W-1:0] half;
   logic              big;
   logic [TAN_W-1:0]  tan_val;

   always_comb begin
      // midpoint equal to the current step: take the sample just written
      mid_son = s1_ff.fwd ? s1_ff.son : rd_data_ff;
      half    = s1_ff.wfull[ANGLE_W-1:1];
      big     = half >= HALF_LIMIT;
      tan_val = big ? '0 : TAN_Q16[half[TAN_IDX_W-1:0]];
      s2_in.vld       = s1_ff.vld;
      s2_in.obj       = s1_ff.obj;
      s2_in.last      = s1_ff.last;
      s2_in.big       = big;
      s2_in.center    = s1_ff.center;
      s2_in.width_deg = s1_ff.wfull[WDEG_W-1:0];
      s2_in.distance  = mid_son;
      s2_in.prod      = PROD_W'(mid_son) * PROD_W'(tan_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign stage2 = s2_ff;
   assign busy   = {1'b0, s1_ff.vld} + {1'b0, s2_ff.vld};

endmodule

/* rtl/core/sos_back.sv */
// -----------------------------------------------------------------------------
// sos_back: linear width, object count and smallest-object tracking
// Rounds and saturates the tangent product, builds the object and summary
// records and keeps the best entry of the sweep.
// -----------------------------------------------------------------------------
module sos_back import sos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  stage2_type stage2,
   output logic [1:0] push_n,
   output rsp_type    rec0,
   output rsp_type    rec1
);

   logic [CNT_W-1:0]   found_ff, found_in;
   logic [CNT_W-1:0]   best_idx_ff, best_idx_in;
   logic [ANGLE_W-1:0] best_ctr_ff, best_ctr_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [LIN_W-1:0]   best_lin_ff, best_lin_in;

   logic [PROD_W:0]  rnd;
   logic [TAN_W-1:0] q;
   logic [LIN_W-1:0] lin;
   logic             obj, take;
   rsp_type          obj_rec, sum_rec;

   always_comb begin
      // 2*d*tan in Q16 rounded half up to Q0: (prod + 2^14) >> 15
      rnd = (PROD_W+1)'(stage2.prod) + (PROD_W+1)'(16384);
      q   = rnd[PROD_W:15];
      if (stage2.big) begin
         lin = (stage2.distance == '0) ? '0 : LIN_MAX;
      end else if (q > TAN_W'(LIN_MAX)) begin
         lin = LIN_MAX;
      end else begin
         lin = q[LIN_W-1:0];
      end
   end

   always_comb begin
      obj  = stage2.vld && stage2.obj;
      take = obj && ((found_ff == '0) || (lin < best_lin_ff));
      found_in     = (obj && (found_ff != CNT_MAX)) ? found_ff + 1'b1 : found_ff;
      best_idx_in  = take ? found_ff        : best_idx_ff;
      best_ctr_in  = take ? stage2.center   : best_ctr_ff;
      best_dist_in = take ? stage2.distance : best_dist_ff;
      best_lin_in  = take ? lin             : best_lin_ff;
   end

   always_comb begin
      obj_rec.kind         = KIND_OBJECT;
      obj_rec.object_index = found_ff;
      obj_rec.center_deg   = stage2.center;
      obj_rec.distance     = stage2.distance;
      obj_rec.width_deg    = stage2.width_deg;
      obj_rec.linear_width = lin;
      obj_rec.object_count = found_in;
      obj_rec.last         = 1'b0;

      sum_rec.kind         = KIND_SUMMARY;
      sum_rec.object_index = best_idx_in;
      sum_rec.center_deg   = best_ctr_in;
      sum_rec.distance     = best_dist_in;
      sum_rec.width_deg    = '0;
      sum_rec.linear_width = best_lin_in;
      sum_rec.object_count = found_in;
      sum_rec.last         = 1'b1;

      // object record goes first when both are due
      rec0   = obj ? obj_rec : sum_rec;
      rec1   = sum_rec;
      push_n = {1'b0, obj} + {1'b0, stage2.vld && stage2.last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= '0;
         best_idx_ff  <= '0;
         best_ctr_ff  <= '0;
         best_dist_ff <= '0;
         best_lin_ff  <= '0;
      end else if (stage2.vld && stage2.last) begin
         found_ff     <= '0;
         best_idx_ff  <= '0;
         best_ctr_ff  <= '0;
         best_dist_ff <= '0;
         best_lin_ff  <= '0;
      end else begin
         found_ff     <= found_in;
         best_idx_ff  <= best_idx_in;
         best_ctr_ff  <= best_ctr_in;
         best_dist_ff <= best_dist_in;
         best_lin_ff  <= best_lin_in;
      end
   end

endmodule

/* rtl/core/sos_out_fifo.sv */
// -----------------------------------------------------------------------------
// sos_out_fifo: result record queue
// Takes up to two records a cycle, hands out one a cycle on each pop.
// -----------------------------------------------------------------------------
module sos_out_fifo import sos_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  rsp_type               rec0,
   input  rsp_type               rec1,
   input  logic                  pop,
   output rsp_type               head,
   output logic                  head_valid,
   output logic [FIFO_CNT_W-1:0] count
);

   rsp_type                 fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_nx;

   always_comb begin
      wr_ptr_nx = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) fifo_mem[wr_ptr_ff] <= rec0;
      if (push_n == 2'd2) fifo_mem[wr_ptr_nx] <= rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head       = fifo_mem[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("record queue overflow");

   a_room_for_two: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
      else $error("double push without room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && (push_n == 2'd0)) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not lower the count");

   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) && (push_n == 2'd0)) |=> !head_valid)
      else $error("record appeared without a push");

endmodule

/* rtl/core/sweep_object_segmenter.sv */
// -----------------------------------------------------------------------------
// sweep_object_segmenter: segments a sensor sweep into objects
// Stores sonar samples by step, finds objects from IR and sonar thresholds,
// reports each object and a per-sweep summary of the narrowest object.
//
//   channel   direction  transaction carries
//   req_chan  in         ir_dist, sonar_dist, last_sample
//   rsp_chan  out        object record or sweep summary
//   csr (APB) in/out     ping_near @0x0, ir_near @0x4, ir_clear @0x8
//
// One sample is taken per cycle while the record queue has room for all
// records still in flight; the first record of a sample passes the stage 1
// and stage 2 registers before the queue. A sample that ends an object on the
// last step yields two records, drained one per cycle while rsp_chan is ready.
// Reset is synchronous and restores the thresholds; the sonar store is not
// cleared. A stalled rsp_chan drops req_chan.ready before the queue overflows.
// -----------------------------------------------------------------------------
module sweep_object_segmenter import sos_pkg::*; #(
   parameter int SWEEP_STEPS  = 91,
   parameter int DEG_PER_STEP = 2
) (
   input  logic              clock,
   input  logic              reset,
   sos_req_if.sink           req_chan,
   sos_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   thresh_type thresh_ff, thresh_in;
   logic       csr_write;

   stage2_type            stage2;
   logic [1:0]            busy;
   logic [1:0]            push_n;
   rsp_type               rec0, rec1, head;
   logic                  head_valid;
   logic [FIFO_CNT_W-1:0] count;
   logic [FIFO_CNT_W+1:0] need;
   logic                  accept;

   // register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_PING_NEAR: thresh_in.ping_near = pwdata[DIST_W-1:0];
            REG_IR_NEAR:   thresh_in.ir_near   = pwdata[DIST_W-1:0];
            REG_IR_CLEAR:  thresh_in.ir_clear  = pwdata[DIST_W-1:0];
            default:       thresh_in = thresh_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_PING_NEAR: prdata = CSR_DW'(thresh_ff.ping_near);
         REG_IR_NEAR:   prdata = CSR_DW'(thresh_ff.ir_near);
         REG_IR_CLEAR:  prdata = CSR_DW'(thresh_ff.ir_clear);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.ping_near <= PING_NEAR_RST;
         thresh_ff.ir_near   <= IR_NEAR_RST;
         thresh_ff.ir_clear  <= IR_CLEAR_RST;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // reserve two queue slots for every sample in flight
   always_comb begin
      need = (FIFO_CNT_W+2)'(count) + (FIFO_CNT_W+2)'({busy, 1'b0})
           + (FIFO_CNT_W+2)'(2);
   end

   assign req_chan.ready = need <= (FIFO_CNT_W+2)'(FIFO_DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;

   sos_front #(
      .SWEEP_STEPS  (SWEEP_STEPS),
      .DEG_PER_STEP (DEG_PER_STEP)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ir_dist     (req_chan.ir_dist),
      .sonar_dist  (req_chan.sonar_dist),
      .last_sample (req_chan.last_sample),
      .thresh      (thresh_ff),
      .stage2      (stage2),
      .busy        (busy)
   );

   sos_back u_back (
      .clock  (clock),
      .reset  (reset),
      .stage2 (stage2),
      .push_n (push_n),
      .rec0   (rec0),
      .rec1   (rec1)
   );

   sos_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .rec0       (rec0),
      .rec1       (rec1),
      .pop        (rsp_chan.valid && rsp_chan.ready),
      .head       (head),
      .head_valid (head_valid),
      .count      (count)
   );

   assign rsp_chan.valid        = head_valid;
   assign rsp_chan.kind         = head.kind;
   assign rsp_chan.object_index = head.object_index;
   assign rsp_chan.center_deg   = head.center_deg;
   assign rsp_chan.distance     = head.distance;
   assign rsp_chan.width_deg    = head.width_deg;
   assign rsp_chan.linear_width = head.linear_width;
   assign rsp_chan.object_count = head.object_count;
   assign rsp_chan.last         = head.last;

endmodule
